>>> rtl/uda_pkg.sv
// Shared types, constants and helpers for the decimal text converter.
package uda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IN_VALUE_W = 32;
    localparam int SIZE_W     = 7;
    localparam int CHAR_W     = 8;

    // Shift width rounded up to a whole number of two-bit steps.
    localparam int SHIFT_W = 2 * ((VALUE_BITS + 1) / 2);
    localparam int STEPS   = SHIFT_W / 2;
    localparam int STEP_W  = $clog2(STEPS);

    // Decimal digits needed for VALUE_BITS: floor(bits * log10(2)) + 1.
    localparam int DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IDX_W   = $clog2(DIGITS);
    localparam int CNT_W   = $clog2(DIGITS + 1);

    localparam int TAIL_CHARS = 3;
    localparam int POS_W      = $clog2(DIGITS + TAIL_CHARS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // Double-dabble correction: add 3 to a BCD digit of 5 or more.
    function automatic logic [3:0] adj3(input logic [3:0] d);
        adj3 = (d >= 4'd5) ? (d + 4'd3) : d;
    endfunction

endpackage

>>> rtl/uda_if.sv
// Valid/ready channel interfaces for number items and text items.
interface uda_in_if;
    logic                          valid;
    logic                          ready;
    logic [uda_pkg::IN_VALUE_W-1:0] value;
    logic [uda_pkg::SIZE_W-1:0]     buffer_size;

    modport source (output valid, output value, output buffer_size, input ready);
    modport sink   (input valid, input value, input buffer_size, output ready);
endinterface

interface uda_out_if;
    logic                       valid;
    logic                       ready;
    logic [uda_pkg::CHAR_W-1:0] char_out;
    logic                       last;
    logic                       fit;

    modport source (output valid, output char_out, output last, output fit, input ready);
    modport sink   (input valid, input char_out, input last, input fit, output ready);
endinterface

>>> rtl/uda_cell.sv
// One BCD digit cell of the shift-and-add-3 chain, two bits per cycle while shift is set.
module uda_cell (
    input  logic                clk,
    input  uda_pkg::cell_ctrl_t ctrl,
    input  logic [1:0]          bits_in,
    output logic [1:0]          bits_out,
    output logic [3:0]          digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj_a;
    logic [3:0] mid;
    logic [3:0] adj_b;

    always_comb
    begin
        adj_a      = uda_pkg::adj3(digit_reg);
        mid        = {adj_a[2:0], bits_in[1]};
        adj_b      = uda_pkg::adj3(mid);
        digit_next = {adj_b[2:0], bits_in[0]};
        // bits leaving toward the next higher digit, first step in the high bit
        bits_out   = {adj_a[3], adj_b[3]};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            digit_reg <= 4'd0;
        end
        else if (ctrl.shift)
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

>>> rtl/uint_to_decimal_ascii.sv
// Top level: unsigned binary to decimal ASCII text, one character per item.
// Each number is accepted, converted in the digit chain and its digits counted;
// then the kept digits and three tail characters go out, one per cycle while
// the sink is ready. A new number is accepted only after the last character;
// the digit-cell chain converts the value two bits per cycle.
// Reset: rst_n, asynchronous active low, clears the sequencer and output valid.
module uint_to_decimal_ascii (
    input  logic      clk,
    input  logic      rst_n,
    uda_in_if.sink    number,
    uda_out_if.source text
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_FIND = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [uda_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [uda_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [uda_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [uda_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                        fit_reg, fit_next;

    logic [uda_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        last_reg, last_next;
    logic                        ofit_reg, ofit_next;
    logic                        out_valid_reg, out_valid_next;

    uda_pkg::cell_ctrl_t         ctrl;
    logic [1:0]                  link [uda_pkg::DIGITS+1];
    logic [3:0]                  digit [uda_pkg::DIGITS];

    logic [63:0]                 val_ext;
    logic [uda_pkg::SHIFT_W-1:0] val_in;
    logic [uda_pkg::CNT_W-1:0]   ndig;
    logic [uda_pkg::SIZE_W-1:0]  limit;
    logic [uda_pkg::CNT_W-1:0]   kept;
    logic                        fits;
    logic                        accept;
    logic                        slot_free;
    logic [uda_pkg::IDX_W-1:0]   rd_idx;
    logic [uda_pkg::POS_W-1:0]   pos_off;

    // digit chain: cell 0 is the units digit, value enters msb first
    assign link[0] = shift_reg[uda_pkg::SHIFT_W-1 -: 2];

    for (genvar g = 0; g < uda_pkg::DIGITS; g++)
    begin : g_cell
        uda_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .bits_in  (link[g]),
            .bits_out (link[g+1]),
            .digit    (digit[g])
        );
    end

    assign accept         = number.valid && number.ready;
    assign number.ready   = (state_reg == ST_IDLE);
    assign slot_free      = !out_valid_reg || text.ready;
    assign text.valid     = out_valid_reg;
    assign text.char_out  = char_reg;
    assign text.last      = last_reg;
    assign text.fit       = ofit_reg;

    assign ctrl.clear = accept;
    assign ctrl.shift = (state_reg == ST_CONV);

    always_comb
    begin
        val_ext = {32'd0, number.value};
        for (int i = 0; i < uda_pkg::SHIFT_W; i++)
        begin
            val_in[i] = (i < uda_pkg::VALUE_BITS) ? val_ext[i] : 1'b0;
        end
    end

    // significant digit count and how many are kept
    always_comb
    begin
        ndig = uda_pkg::CNT_W'(1);
        for (int i = 1; i < uda_pkg::DIGITS; i++)
        begin
            if (digit[i] != 4'd0)
            begin
                ndig = uda_pkg::CNT_W'(i + 1);
            end
        end
        if (size_reg > uda_pkg::SIZE_W'(uda_pkg::TAIL_CHARS))
        begin
            limit = size_reg - uda_pkg::SIZE_W'(uda_pkg::TAIL_CHARS);
        end
        else
        begin
            limit = uda_pkg::SIZE_W'(1);
        end
        fits = (uda_pkg::SIZE_W'(ndig) <= limit);
        kept = fits ? ndig : uda_pkg::CNT_W'(limit);
    end

    assign pos_off = pos_reg - uda_pkg::POS_W'(uda_pkg::TAIL_CHARS);
    assign rd_idx  = pos_off[uda_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        size_next      = size_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        fit_next       = fit_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        ofit_next      = ofit_reg;
        out_valid_next = out_valid_reg;

        if (text.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    shift_next = val_in;
                    size_next  = number.buffer_size;
                    step_next  = uda_pkg::STEP_W'(uda_pkg::STEPS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                shift_next = shift_reg << 2;
                step_next  = step_reg - uda_pkg::STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                pos_next   = uda_pkg::POS_W'(kept) + uda_pkg::POS_W'(uda_pkg::TAIL_CHARS - 1);
                fit_next   = fits;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    ofit_next      = fit_reg;
                    last_next      = 1'b0;
                    if (pos_reg >= uda_pkg::POS_W'(uda_pkg::TAIL_CHARS))
                    begin
                        char_next = uda_pkg::CHAR_ZERO | {4'd0, digit[rd_idx]};
                    end
                    else if (pos_reg == uda_pkg::POS_W'(uda_pkg::TAIL_CHARS - 1))
                    begin
                        char_next = uda_pkg::CHAR_LF;
                    end
                    else if (pos_reg != '0)
                    begin
                        char_next = uda_pkg::CHAR_CR;
                    end
                    else
                    begin
                        char_next = uda_pkg::CHAR_NUL;
                        last_next = 1'b1;
                    end
                    pos_next = pos_reg - uda_pkg::POS_W'(1);
                    if (pos_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        size_reg  <= size_next;
        step_reg  <= step_next;
        pos_reg   <= pos_next;
        fit_reg   <= fit_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        ofit_reg  <= ofit_next;
    end

endmodule
